FILE: hdl/pbo_pkg.sv
`default_nettype none

package pbo_pkg;

    localparam int ENTRIES_DEF = 8;

    localparam logic [7:0] CODE_POOL_RST         = 8'd1;
    localparam logic [7:0] CODE_MAC_TO_UPPER_RST = 8'd2;
    localparam logic [7:0] CODE_MAC_RST          = 8'd3;
    localparam logic [7:0] CODE_UPPER_TO_MAC_RST = 8'd4;
    localparam logic [7:0] CODE_UPPER_RST        = 8'd5;

    typedef enum logic [2:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_CLEAR = 3'd2,
        OP_SENT  = 3'd3,
        OP_RECV  = 3'd4,
        OP_DATA  = 3'd5,
        OP_ADV   = 3'd6,
        OP_WRITE = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_UNUSED = 2'd1,
        ST_BAD    = 2'd2,
        ST_NONE   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        HK_NONE  = 2'd0,
        HK_SHORT = 2'd1,
        HK_LONG  = 2'd2
    } t_hop_kind;

    typedef enum logic [1:0] {
        TK_UNICAST = 2'd0,
        TK_ANYCAST = 2'd1
    } t_target_kind;

    typedef enum logic [2:0] {
        REG_POOL         = 3'd0,
        REG_MAC_TO_UPPER = 3'd1,
        REG_MAC          = 3'd2,
        REG_UPPER_TO_MAC = 3'd3,
        REG_UPPER        = 3'd4
    } t_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  slot;
        logic [7:0]  owner_code;
        logic [7:0]  creator_code;
        logic [1:0]  hop_kind;
        logic [63:0] hop_address;
        logic [1:0]  target_kind;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] entry_index;
    } t_result;

    typedef struct packed {
        logic [7:0]  owner;
        logic [7:0]  creator;
        logic [1:0]  hop_kind;
        logic [63:0] hop_address;
    } t_entry;

    typedef struct packed {
        logic [7:0] pool;
        logic [7:0] mac_to_upper;
        logic [7:0] mac;
        logic [7:0] upper_to_mac;
        logic [7:0] upper;
    } t_codes;

    typedef struct packed {
        logic wr;
        logic clr;
    } t_mem_ctl;

    function automatic logic f_bcast(logic [1:0] kind, logic [63:0] addr);
        logic b;
        b = 1'b0;
        if (kind == HK_SHORT) begin
            b = (addr[15:0] == 16'hFFFF);
        end else if (kind == HK_LONG) begin
            b = (addr == 64'hFFFF_FFFF_FFFF_FFFF);
        end
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/pbo_mem.sv
`default_nettype none

module pbo_mem #(
    parameter int ENTRIES = pbo_pkg::ENTRIES_DEF,
    localparam int IW = $clog2(ENTRIES)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [IW-1:0]     i_addr,
    input  wire pbo_pkg::t_mem_ctl i_ctl,
    input  wire pbo_pkg::t_entry   i_wdata,
    output pbo_pkg::t_entry        o_rdata
);
    import pbo_pkg::*;

    t_entry               r_mem [ENTRIES];
    t_entry               r_rdata;
    logic [ENTRIES-1:0]   r_valid;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_addr];
            if (i_ctl.wr) begin
                r_valid[i_addr] <= 1'b1;
            end else if (i_ctl.clr) begin
                r_valid[i_addr] <= 1'b0;
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

`default_nettype wire

FILE: hdl/pbo_ctrl.sv
`default_nettype none

module pbo_ctrl #(
    parameter int ENTRIES = pbo_pkg::ENTRIES_DEF,
    localparam int IW = $clog2(ENTRIES)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire pbo_pkg::t_cmd     i_cmd,
    input  wire pbo_pkg::t_codes   i_codes,
    output logic                   o_busy,
    output logic                   o_strobe,
    output pbo_pkg::t_result       o_result,
    output logic [IW-1:0]          o_addr,
    output pbo_pkg::t_mem_ctl      o_ctl,
    output pbo_pkg::t_entry        o_wdata,
    input  wire pbo_pkg::t_entry   i_rdata
);
    import pbo_pkg::*;

    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [IW-1:0] r_idx, n_idx;
    logic [1:0]    r_status, n_status;
    logic [5:0]    r_index, n_index;
    logic          accept;
    logic          slot_bad;
    logic          eval_done;
    logic          hit;

    function automatic logic f_match(t_entry e, t_cmd c, t_codes k);
        logic b;
        logic m;
        b = f_bcast(e.hop_kind, e.hop_address);
        m = 1'b0;
        case (c.operation)
            OP_SENT: m = (e.owner == k.mac_to_upper) && (e.creator != k.mac);
            OP_RECV: m = (e.owner == k.mac_to_upper) && (e.creator == k.mac);
            OP_DATA: begin
                if (c.target_kind == TK_UNICAST) begin
                    m = (e.owner == k.upper_to_mac) && (e.hop_kind == HK_LONG)
                        && (e.hop_address == c.hop_address);
                end else if (c.target_kind == TK_ANYCAST) begin
                    m = (e.owner == k.upper_to_mac) && ((e.creator != k.upper) || !b);
                end
            end
            OP_ADV: m = (e.owner == k.upper_to_mac) && (e.creator == k.upper) && b;
            default: m = 1'b0;
        endcase
        return m;
    endfunction

    assign accept   = i_start && (r_state == S_IDLE);
    assign slot_bad = (32'(i_cmd.slot) >= 32'(ENTRIES));
    assign hit      = f_match(i_rdata, r_cmd, i_codes);

    always_comb begin
        case (r_cmd.operation)
            OP_ALLOC: eval_done = (i_rdata.owner == 8'd0) || (r_idx == LAST);
            OP_FREE:  eval_done = 1'b1;
            OP_WRITE: eval_done = 1'b1;
            OP_CLEAR: eval_done = (r_idx == LAST);
            default:  eval_done = hit || (r_idx == LAST);
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_cmd.operation == OP_FREE || i_cmd.operation == OP_WRITE)
                        && slot_bad) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD:   n_state = S_EVAL;
            S_EVAL: n_state = eval_done ? S_RESP : S_RD;
            S_RESP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_status = r_status;
        n_index  = r_index;
        o_ctl    = '0;
        o_wdata  = i_rdata;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd    = i_cmd;
                    n_index  = 6'd0;
                    n_idx    = '0;
                    n_status = (i_cmd.operation == OP_CLEAR) ? ST_OK : ST_NONE;
                    if (i_cmd.operation == OP_FREE || i_cmd.operation == OP_WRITE) begin
                        if (slot_bad) begin
                            n_status = ST_BAD;
                        end else begin
                            n_idx = i_cmd.slot[IW-1:0];
                        end
                    end
                end
            end
            S_EVAL: begin
                case (r_cmd.operation)
                    OP_ALLOC: begin
                        o_wdata.owner = i_codes.pool;
                        if (i_rdata.owner == 8'd0) begin
                            o_ctl.wr = 1'b1;
                            n_status = ST_OK;
                            n_index  = 6'(r_idx);
                        end
                    end
                    OP_FREE: begin
                        o_ctl.clr = 1'b1;
                        n_status  = (i_rdata.owner == 8'd0) ? ST_UNUSED : ST_OK;
                        n_index   = 6'(r_idx);
                    end
                    OP_CLEAR: begin
                        o_ctl.clr = (i_rdata.owner == r_cmd.owner_code);
                    end
                    OP_WRITE: begin
                        o_wdata.owner       = r_cmd.owner_code;
                        o_wdata.creator     = r_cmd.creator_code;
                        o_wdata.hop_kind    = r_cmd.hop_kind;
                        o_wdata.hop_address = r_cmd.hop_address;
                        o_ctl.wr            = 1'b1;
                        n_status            = ST_OK;
                        n_index             = 6'(r_idx);
                    end
                    default: begin
                        if (hit) begin
                            n_status = ST_OK;
                            n_index  = 6'(r_idx);
                        end
                    end
                endcase
                if (!eval_done) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_index  <= n_index;
    end

    assign o_addr               = r_idx;
    assign o_busy               = (r_state != S_IDLE);
    assign o_strobe             = (r_state == S_RESP);
    assign o_result.status      = r_status;
    assign o_result.entry_index = r_index;

    a_strobe_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_busy)
        else $error("result strobe not followed by idle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not raise busy");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status == ST_BAD || o_result.status == ST_NONE))
        |-> (o_result.entry_index == 6'd0))
        else $error("nonzero index on failed transaction");

    a_write_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.wr || o_ctl.clr) |-> (r_state == S_EVAL))
        else $error("table update outside evaluation");

    a_wr_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl.wr && o_ctl.clr))
        else $error("write and clear together");

endmodule

`default_nettype wire

FILE: hdl/packet_buffer_pool_owner_table.sv
// Channel   Signals                                         Direction
// command   i_start, o_busy, i_cmd                          in
// result    o_strobe, o_result                              out
// config    i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data  in
//
// A transaction visits table entries, each with a memory read and then an
// evaluate and write-back, and ends in a result state. Clear visits every
// entry, alloc and the searches stop at the first free or matching one, free
// and write visit only their slot; a bad slot goes straight to the result.
// Reset is synchronous and clears the valid bits, so the table reads as free
// at once. The result is shown for one cycle and cannot be stalled.
`default_nettype none

module packet_buffer_pool_owner_table #(
    parameter int ENTRIES = pbo_pkg::ENTRIES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire pbo_pkg::t_cmd    i_cmd,
    output logic                  o_strobe,
    output pbo_pkg::t_result      o_result,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [2:0]       i_cfg_index,
    input  wire logic [7:0]       i_cfg_data
);
    import pbo_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    t_codes        r_codes;
    logic [IW-1:0] addr;
    t_mem_ctl      ctl;
    t_entry        wdata;
    t_entry        rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.pool         <= CODE_POOL_RST;
            r_codes.mac_to_upper <= CODE_MAC_TO_UPPER_RST;
            r_codes.mac          <= CODE_MAC_RST;
            r_codes.upper_to_mac <= CODE_UPPER_TO_MAC_RST;
            r_codes.upper        <= CODE_UPPER_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_POOL:         r_codes.pool         <= i_cfg_data;
                REG_MAC_TO_UPPER: r_codes.mac_to_upper <= i_cfg_data;
                REG_MAC:          r_codes.mac          <= i_cfg_data;
                REG_UPPER_TO_MAC: r_codes.upper_to_mac <= i_cfg_data;
                REG_UPPER:        r_codes.upper        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pbo_ctrl #(
        .ENTRIES(ENTRIES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .i_codes  (r_codes),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .o_addr   (addr),
        .o_ctl    (ctl),
        .o_wdata  (wdata),
        .i_rdata  (rdata)
    );

    pbo_mem #(
        .ENTRIES(ENTRIES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (addr),
        .i_ctl   (ctl),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import pbo_pkg::*;

    localparam int NUM_ENTRIES  = ENTRIES_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 205;

    typedef enum logic [1:0] {
        JOB_CMD,
        JOB_CFG,
        JOB_DRAIN
    } t_job_kind;

    typedef struct {
        t_job_kind   kind;
        t_cmd        cmd;
        logic [2:0]  reg_idx;
        logic [7:0]  reg_val;
        int unsigned idle_pct;
    } t_job;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_start     = 1'b0;
    t_cmd       i_cmd       = '0;
    logic       i_cfg_valid = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data  = '0;
    logic       o_busy;
    logic       o_strobe;
    logic       o_cfg_ready;
    t_result    o_result;

    t_job        pending_jobs[$];
    t_result     expected_results[$];
    t_entry      descriptors[NUM_ENTRIES];
    t_codes      codes;
    logic [63:0] addr_pool[4];
    int unsigned gen_idle_pct   = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    packet_buffer_pool_owner_table #(
        .ENTRIES(NUM_ENTRIES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_cmd      (i_cmd),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic hop_is_bcast(t_entry e);
        if (e.hop_kind == HK_SHORT) begin
            return &e.hop_address[15:0];
        end
        if (e.hop_kind == HK_LONG) begin
            return &e.hop_address;
        end
        return 1'b0;
    endfunction

    function automatic logic entry_hits(t_entry e, t_cmd c);
        case (t_op'(c.operation))
            OP_SENT: return e.owner == codes.mac_to_upper && e.creator != codes.mac;
            OP_RECV: return e.owner == codes.mac_to_upper && e.creator == codes.mac;
            OP_DATA: begin
                if (e.owner != codes.upper_to_mac) begin
                    return 1'b0;
                end
                if (c.target_kind == TK_UNICAST) begin
                    return e.hop_kind == HK_LONG && e.hop_address == c.hop_address;
                end
                if (c.target_kind == TK_ANYCAST) begin
                    return e.creator != codes.upper || !hop_is_bcast(e);
                end
                return 1'b0;
            end
            OP_ADV: begin
                return e.owner == codes.upper_to_mac && e.creator == codes.upper
                    && hop_is_bcast(e);
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic predict_result(input t_cmd c);
        t_result r;
        logic    hit;
        int      i;
        r.status      = ST_NONE;
        r.entry_index = '0;
        hit           = 1'b0;
        case (t_op'(c.operation))
            OP_ALLOC: begin
                for (i = 0; i < NUM_ENTRIES; i++) begin
                    if (!hit && descriptors[i].owner == 8'd0) begin
                        descriptors[i].owner = codes.pool;
                        r.status      = ST_OK;
                        r.entry_index = i[5:0];
                        hit           = 1'b1;
                    end
                end
            end
            OP_FREE: begin
                if (c.slot < NUM_ENTRIES) begin
                    r.status = (descriptors[c.slot].owner == 8'd0) ? ST_UNUSED : ST_OK;
                    r.entry_index = c.slot[5:0];
                    descriptors[c.slot] = '0;
                end else begin
                    r.status = ST_BAD;
                end
            end
            OP_CLEAR: begin
                for (i = 0; i < NUM_ENTRIES; i++) begin
                    if (descriptors[i].owner == c.owner_code) begin
                        descriptors[i] = '0;
                    end
                end
                r.status = ST_OK;
            end
            OP_WRITE: begin
                if (c.slot < NUM_ENTRIES) begin
                    descriptors[c.slot].owner       = c.owner_code;
                    descriptors[c.slot].creator     = c.creator_code;
                    descriptors[c.slot].hop_kind    = c.hop_kind;
                    descriptors[c.slot].hop_address = c.hop_address;
                    r.status      = ST_OK;
                    r.entry_index = c.slot[5:0];
                end else begin
                    r.status = ST_BAD;
                end
            end
            default: begin
                for (i = 0; i < NUM_ENTRIES; i++) begin
                    if (!hit && entry_hits(descriptors[i], c)) begin
                        r.status      = ST_OK;
                        r.entry_index = i[5:0];
                        hit           = 1'b1;
                    end
                end
            end
        endcase
        expected_results.push_back(r);
    endtask

    task automatic apply_register(input logic [2:0] idx, input logic [7:0] val);
        case (t_reg'(idx))
            REG_POOL:         codes.pool         = val;
            REG_MAC_TO_UPPER: codes.mac_to_upper = val;
            REG_MAC:          codes.mac          = val;
            REG_UPPER_TO_MAC: codes.upper_to_mac = val;
            REG_UPPER:        codes.upper        = val;
            default: ;
        endcase
    endtask

    task automatic queue_cmd(input t_op op, input logic [7:0] slot, input logic [7:0] owner,
                             input logic [7:0] creator, input logic [1:0] hkind,
                             input logic [63:0] addr, input logic [1:0] tkind);
        t_job j;
        j.kind             = JOB_CMD;
        j.cmd.operation    = op;
        j.cmd.slot         = slot;
        j.cmd.owner_code   = owner;
        j.cmd.creator_code = creator;
        j.cmd.hop_kind     = hkind;
        j.cmd.hop_address  = addr;
        j.cmd.target_kind  = tkind;
        j.reg_idx          = '0;
        j.reg_val          = '0;
        j.idle_pct         = gen_idle_pct;
        pending_jobs.push_back(j);
    endtask

    task automatic queue_cfg(input t_reg idx, input logic [7:0] val);
        t_job j;
        j.kind     = JOB_CFG;
        j.cmd      = '0;
        j.reg_idx  = idx;
        j.reg_val  = val;
        j.idle_pct = 0;
        pending_jobs.push_back(j);
    endtask

    task automatic queue_drain();
        t_job j;
        j.kind     = JOB_DRAIN;
        j.cmd      = '0;
        j.reg_idx  = '0;
        j.reg_val  = '0;
        j.idle_pct = 0;
        pending_jobs.push_back(j);
    endtask

    task automatic queue_codes(input t_codes k);
        queue_drain();
        queue_cfg(REG_POOL, k.pool);
        queue_cfg(REG_MAC_TO_UPPER, k.mac_to_upper);
        queue_cfg(REG_MAC, k.mac);
        queue_cfg(REG_UPPER_TO_MAC, k.upper_to_mac);
        queue_cfg(REG_UPPER, k.upper);
    endtask

    function automatic logic [7:0] pick_code(t_codes k);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            case ($urandom_range(0, 4))
                0: return k.pool;
                1: return k.mac_to_upper;
                2: return k.mac;
                3: return k.upper_to_mac;
                default: return k.upper;
            endcase
        end
        if (r == 7) begin
            return 8'd0;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [63:0] pick_addr();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return {$urandom, $urandom} | 64'hFFFF;
            2, 3: return addr_pool[$urandom_range(0, 3)];
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_random_cmd(input t_codes k);
        int unsigned r;
        t_op         op;
        logic [7:0]  slot;
        r = $urandom_range(0, 99);
        if (r < 12)      op = OP_ALLOC;
        else if (r < 24) op = OP_FREE;
        else if (r < 29) op = OP_CLEAR;
        else if (r < 37) op = OP_SENT;
        else if (r < 45) op = OP_RECV;
        else if (r < 62) op = OP_DATA;
        else if (r < 72) op = OP_ADV;
        else             op = OP_WRITE;
        if ($urandom_range(0, 99) < 85) begin
            slot = 8'($urandom_range(0, NUM_ENTRIES - 1));
        end else begin
            slot = 8'($urandom_range(0, 255));
        end
        queue_cmd(op, slot, pick_code(k), pick_code(k), 2'($urandom_range(0, 3)),
                  pick_addr(), 2'($urandom_range(0, 3)));
    endtask

    always @(posedge i_clk) begin : drive
        logic start_nxt;
        logic cfg_nxt;
        t_job job;
        start_nxt = i_start;
        cfg_nxt   = i_cfg_valid;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                predict_result(i_cmd);
                start_nxt = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register(i_cfg_index, i_cfg_data);
                cfg_nxt = 1'b0;
            end
            if (!start_nxt && !cfg_nxt && pending_jobs.size() > 0) begin
                job = pending_jobs[0];
                case (job.kind)
                    JOB_DRAIN: begin
                        if (!o_busy && !o_strobe && !i_start
                                && expected_results.size() == 0) begin
                            quiet_cycles++;
                        end else begin
                            quiet_cycles = 0;
                        end
                        if (quiet_cycles >= DRAIN_CYCLES) begin
                            quiet_cycles = 0;
                            void'(pending_jobs.pop_front());
                        end
                    end
                    JOB_CFG: begin
                        cfg_nxt = 1'b1;
                        i_cfg_index <= job.reg_idx;
                        i_cfg_data  <= job.reg_val;
                        void'(pending_jobs.pop_front());
                    end
                    default: begin
                        if ($urandom_range(0, 99) >= job.idle_pct) begin
                            start_nxt = 1'b1;
                            i_cmd <= job.cmd;
                            void'(pending_jobs.pop_front());
                        end
                    end
                endcase
            end
        end
        i_start     <= start_nxt;
        i_cfg_valid <= cfg_nxt;
    end

    always @(posedge i_clk) begin : check
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("tb: result with no transaction pending: status %0d index %0d",
                             o_result.status, o_result.entry_index);
                end
            end else begin
                want = expected_results.pop_front();
                if (o_result.status != want.status
                        || o_result.entry_index != want.entry_index) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"tb: mismatch: expected status %0d index %0d, ",
                                  "got status %0d index %0d"},
                                 want.status, want.entry_index,
                                 o_result.status, o_result.entry_index);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        t_codes      phase_codes[PHASES];
        int unsigned phase_idle[PHASES];
        int          p;
        int          n;
        codes.pool         = CODE_POOL_RST;
        codes.mac_to_upper = CODE_MAC_TO_UPPER_RST;
        codes.mac          = CODE_MAC_RST;
        codes.upper_to_mac = CODE_UPPER_TO_MAC_RST;
        codes.upper        = CODE_UPPER_RST;
        for (n = 0; n < NUM_ENTRIES; n++) begin
            descriptors[n] = '0;
        end
        for (n = 0; n < 4; n++) begin
            addr_pool[n] = {$urandom, $urandom};
        end

        queue_cmd(OP_FREE, 8'd0, 8'd0, 8'd0, HK_NONE, '0, TK_UNICAST);
        queue_cmd(OP_ALLOC, 8'd0, 8'd0, 8'd0, HK_NONE, '0, TK_UNICAST);
        queue_cmd(OP_WRITE, 8'd1, 8'd2, 8'd3, HK_NONE, '0, TK_UNICAST);
        queue_cmd(OP_WRITE, 8'd2, 8'd2, 8'd9, HK_SHORT, 64'h1234, TK_UNICAST);
        queue_cmd(OP_SENT, 8'd0, 8'd0, 8'd0, HK_NONE, '0, TK_UNICAST);
        queue_cmd(OP_RECV, 8'd0, 8'd0, 8'd0, HK_NONE, '0, TK_UNICAST);
        queue_cmd(OP_WRITE, 8'd3, 8'd4, 8'd5, HK_LONG, '1, TK_UNICAST);
        queue_cmd(OP_WRITE, 8'd4, 8'd4, 8'd5, HK_SHORT, 64'h0123_4567_89AB_FFFF, TK_UNICAST);
        queue_cmd(OP_WRITE, 8'd5, 8'd4, 8'd7, 2'd3, '1, TK_UNICAST);
        queue_cmd(OP_WRITE, 8'd6, 8'd4, 8'd5, HK_LONG, 64'hDEAD_BEEF_0BAD_F00D, TK_UNICAST);
        queue_cmd(OP_DATA, 8'd0, 8'd0, 8'd0, HK_NONE, 64'hDEAD_BEEF_0BAD_F00D, TK_UNICAST);
        queue_cmd(OP_DATA, 8'd0, 8'd0, 8'd0, HK_NONE, '0, TK_ANYCAST);
        queue_cmd(OP_DATA, 8'd0, 8'd0, 8'd0, HK_NONE, '1, 2'd2);
        queue_cmd(OP_DATA, 8'd0, 8'd0, 8'd0, HK_NONE, '1, 2'd3);
        queue_cmd(OP_ADV, 8'd0, 8'd0, 8'd0, HK_NONE, '0, TK_UNICAST);
        queue_cmd(OP_WRITE, 8'd255, 8'd4, 8'd5, HK_LONG, '1, TK_UNICAST);
        queue_cmd(OP_FREE, 8'd8, 8'd0, 8'd0, HK_NONE, '0, TK_UNICAST);
        queue_cmd(OP_FREE, 8'd255, 8'd0, 8'd0, HK_NONE, '0, TK_UNICAST);
        queue_cmd(OP_CLEAR, 8'd0, 8'd4, 8'd0, HK_NONE, '0, TK_UNICAST);
        queue_cmd(OP_ADV, 8'd0, 8'd0, 8'd0, HK_NONE, '0, TK_UNICAST);
        queue_cmd(OP_WRITE, 8'd7, 8'd255, 8'd255, HK_LONG, '0, 2'd3);
        queue_cmd(OP_FREE, 8'd7, 8'd0, 8'd0, HK_NONE, '0, TK_UNICAST);
        queue_cmd(OP_CLEAR, 8'd0, 8'd0, 8'd0, HK_NONE, '0, TK_UNICAST);
        queue_drain();
        queue_cfg(REG_POOL, 8'd0);
        queue_cmd(OP_ALLOC, 8'd0, 8'd0, 8'd0, HK_NONE, '0, TK_UNICAST);
        queue_cmd(OP_ALLOC, 8'd0, 8'd0, 8'd0, HK_NONE, '0, TK_UNICAST);

        phase_codes[0] = {CODE_POOL_RST, CODE_MAC_TO_UPPER_RST, CODE_MAC_RST,
                          CODE_UPPER_TO_MAC_RST, CODE_UPPER_RST};
        phase_codes[1] = '0;
        phase_codes[2] = '1;
        phase_codes[3] = {8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                          8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                          8'($urandom_range(0, 15))};
        phase_codes[4] = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255))};
        phase_codes[5] = {8'd250, 8'd7, 8'd128, 8'd255, 8'd1};
        phase_idle = '{0, 67, 29, 0, 67, 29};

        for (p = 0; p < PHASES; p++) begin
            queue_codes(phase_codes[p]);
            gen_idle_pct = phase_idle[p];
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    queue_drain();
                end
                queue_random_cmd(phase_codes[p]);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_jobs.size() != 0 || i_start || i_cfg_valid
                || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (2 * NUM_ENTRIES + 8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
